// ----- hdl/bgu_pkg.sv -----
// shared types and codes for the bounded graph urn step block
// used by bgu_mod and bounded_graph_urn_step, no dependencies
package bgu_pkg;

    localparam logic [2:0] FN_LOAD_ROW = 3'd0;
    localparam logic [2:0] FN_LOAD_CAP = 3'd1;
    localparam logic [2:0] FN_PLACE    = 3'd2;
    localparam logic [2:0] FN_MOVE     = 3'd3;
    localparam logic [2:0] FN_READ     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NO_NB = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [4:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic       done;
        logic [3:0] rem;
    } t_mod_rsp;

endpackage

// ----- hdl/bgu_mod.sv -----
// iterative restoring remainder unit, one dividend bit per cycle
// divisor 1 to 16, remainder valid with the done pulse; uses bgu_pkg
module bgu_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgu_pkg::t_mod_req i_req,
    output bgu_pkg::t_mod_rsp o_rsp
);
    import bgu_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_dvd;
    logic [4:0]  r_div;
    logic [3:0]  r_rem;

    logic [4:0]  trial;
    logic [4:0]  diff;

    // remainder stays below the divisor, so four bits plus the shifted-in bit suffice
    assign trial = {r_rem, r_dvd[15]};
    assign diff  = trial - r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 4'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 4'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= 4'd15;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= 4'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            r_dvd <= {r_dvd[14:0], 1'b0};
            if (trial >= r_div) begin
                r_rem <= diff[3:0];
            end else begin
                r_rem <= trial[3:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hdl/bounded_graph_urn_step.sv -----
// capacity-bounded particle urn on a small graph, one command per beat
// per-node adjacency, capacity and occupancy stores; uses bgu_pkg and bgu_mod
//
// input channel: i_valid / o_stall carry func, node, row_mask, capacity_value
// and pick. output channel: o_valid / i_stall carry status, target_node and
// the two counts. every input beat gives exactly one output beat.
// the block works on one command at a time; o_stall is high while a command
// is in flight, and also while a finished result waits and the receiver stalls.
// o_valid rises out of the evaluate state for loads, placements, reads and moves
// that stop at an empty origin or a node without neighbors. a move that gets
// to the target check passes through evaluate, the 16-step remainder unit that
// reduces pick by the neighbor count, the neighbor bit scan, the states that
// read and test the target, and, when the particle moves, one more state for
// the second write through the single occupancy write port. a new command is
// taken at the edge where the result beat leaves.
// reset clears the valid bits of all three stores at once, so every entry
// reads as zero afterwards; no clearing pass is needed.
// while i_stall is high a finished result holds on the output registers.
module bounded_graph_urn_step #(
    parameter int NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_node,
    input  logic [15:0] i_row_mask,
    input  logic [15:0] i_capacity_value,
    input  logic [15:0] i_pick,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_target_node,
    output logic [15:0] o_origin_count,
    output logic [15:0] o_target_count
);
    import bgu_pkg::*;

    // the node field only reaches the first sixteen nodes
    localparam int DEPTH = (NODES < 16) ? NODES : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [15:0] REACH = 16'((17'(1) << DEPTH) - 17'(1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_SCAN,
        S_TADDR,
        S_TEVAL,
        S_WR2
    } t_state;

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [1:0] l1 [8];
        logic [2:0] l2 [4];
        logic [3:0] l3 [2];
        for (int i = 0; i < 8; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 4; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 2; i++) l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

    // stores and their valid bits
    logic [15:0]      m_adj [DEPTH];
    logic [15:0]      m_cap [DEPTH];
    logic [15:0]      m_occ [DEPTH];
    logic [DEPTH-1:0] r_adj_vld;
    logic [DEPTH-1:0] r_cap_vld;
    logic [DEPTH-1:0] r_occ_vld;
    logic [15:0]      r_adj_q;
    logic [15:0]      r_cap_q;
    logic [15:0]      r_occ_q;
    logic             r_adj_qv;
    logic             r_cap_qv;
    logic             r_occ_qv;

    // sequencer registers
    t_state      r_state, n_state;
    logic [2:0]  r_func, n_func;
    logic [3:0]  r_node, n_node;
    logic [15:0] r_row, n_row;
    logic [15:0] r_cap_in, n_cap_in;
    logic [15:0] r_pick, n_pick;
    logic [15:0] r_nb, n_nb;
    logic [3:0]  r_k, n_k;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_target, n_target;
    logic [15:0] r_occ_o, n_occ_o;
    logic [15:0] r_tcnt, n_tcnt;
    logic        r_ov, n_ov;
    logic [1:0]  r_o_status, n_o_status;
    logic [3:0]  r_o_target, n_o_target;
    logic [15:0] r_o_ocnt, n_o_ocnt;
    logic [15:0] r_o_tcnt, n_o_tcnt;

    logic          in_acc;
    logic          node_ok;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] node_idx;
    logic [15:0]   adj_rd;
    logic [15:0]   cap_rd;
    logic [15:0]   occ_rd;
    logic [15:0]   nb;
    logic [4:0]    nb_cnt;
    logic          adj_we;
    logic          cap_we;
    logic          occ_we;
    logic [AW-1:0] occ_wa;
    logic [15:0]   occ_wd;
    t_mod_req      mod_req;
    t_mod_rsp      mod_rsp;

    bgu_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign o_stall  = (r_state != S_IDLE) || (r_ov && i_stall);
    assign in_acc   = i_valid && !o_stall;
    assign node_ok  = {1'b0, r_node} < 5'(DEPTH);
    assign node_idx = r_node[AW-1:0];
    assign rd_idx   = (r_state == S_IDLE) ? i_node[AW-1:0] : r_target[AW-1:0];

    assign adj_rd = r_adj_qv ? r_adj_q : 16'd0;
    assign cap_rd = r_cap_qv ? r_cap_q : 16'd0;
    assign occ_rd = r_occ_qv ? r_occ_q : 16'd0;
    assign nb     = adj_rd & REACH;
    assign nb_cnt = popcount16(nb);

    always_ff @(posedge i_clk) begin
        if (adj_we) m_adj[node_idx] <= r_row;
        if (cap_we) m_cap[node_idx] <= r_cap_in;
        if (occ_we) m_occ[occ_wa] <= occ_wd;
        r_adj_q <= m_adj[rd_idx];
        r_cap_q <= m_cap[rd_idx];
        r_occ_q <= m_occ[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_vld <= '0;
            r_cap_vld <= '0;
            r_occ_vld <= '0;
            r_adj_qv  <= 1'b0;
            r_cap_qv  <= 1'b0;
            r_occ_qv  <= 1'b0;
        end else begin
            if (adj_we) r_adj_vld[node_idx] <= 1'b1;
            if (cap_we) r_cap_vld[node_idx] <= 1'b1;
            if (occ_we) r_occ_vld[occ_wa] <= 1'b1;
            r_adj_qv <= r_adj_vld[rd_idx];
            r_cap_qv <= r_cap_vld[rd_idx];
            r_occ_qv <= r_occ_vld[rd_idx];
        end
    end

    always_comb begin
        logic [15:0] ocnt;
        logic        finish;
        n_state    = r_state;
        n_func     = r_func;
        n_node     = r_node;
        n_row      = r_row;
        n_cap_in   = r_cap_in;
        n_pick     = r_pick;
        n_nb       = r_nb;
        n_k        = r_k;
        n_idx      = r_idx;
        n_target   = r_target;
        n_occ_o    = r_occ_o;
        n_tcnt     = r_tcnt;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_target = r_o_target;
        n_o_ocnt   = r_o_ocnt;
        n_o_tcnt   = r_o_tcnt;
        adj_we     = 1'b0;
        cap_we     = 1'b0;
        occ_we     = 1'b0;
        occ_wa     = node_idx;
        occ_wd     = 16'(occ_rd + 16'd1);
        mod_req.start    = 1'b0;
        mod_req.dividend = r_pick;
        mod_req.divisor  = nb_cnt;
        ocnt   = node_ok ? occ_rd : 16'd0;
        finish = 1'b0;

        if (r_ov && !i_stall) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_func;
                    n_node   = i_node;
                    n_row    = i_row_mask;
                    n_cap_in = i_capacity_value;
                    n_pick   = i_pick;
                    n_target = i_node;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                finish     = 1'b1;
                n_o_status = ST_OK;
                n_o_target = r_node;
                n_o_ocnt   = ocnt;
                n_o_tcnt   = ocnt;
                case (r_func)
                    FN_LOAD_ROW: adj_we = node_ok;
                    FN_LOAD_CAP: cap_we = node_ok;
                    FN_PLACE: begin
                        if (node_ok && (occ_rd < cap_rd)) begin
                            occ_we   = 1'b1;
                            n_o_ocnt = occ_wd;
                            n_o_tcnt = occ_wd;
                        end else begin
                            n_o_status = ST_FULL;
                        end
                    end
                    FN_MOVE: begin
                        if (!node_ok || (occ_rd == 16'd0)) begin
                            n_o_status = ST_EMPTY;
                        end else if (nb_cnt == 5'd0) begin
                            n_o_status = ST_NO_NB;
                        end else begin
                            finish        = 1'b0;
                            mod_req.start = 1'b1;
                            n_nb          = nb;
                            n_occ_o       = occ_rd;
                            n_state       = S_MOD;
                        end
                    end
                    default: ;
                endcase
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_k     = mod_rsp.rem;
                    n_idx   = 4'd0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // walk set bits in ascending order until the k-th one
                n_idx = r_idx + 4'd1;
                if (r_nb[r_idx]) begin
                    if (r_k == 4'd0) begin
                        n_target = r_idx;
                        n_state  = S_TADDR;
                    end else begin
                        n_k = r_k - 4'd1;
                    end
                end
            end
            S_TADDR: begin
                n_state = S_TEVAL;
            end
            S_TEVAL: begin
                n_o_target = r_target;
                if (occ_rd < cap_rd) begin
                    n_o_status = ST_OK;
                    if (r_target == r_node) begin
                        finish   = 1'b1;
                        n_o_ocnt = r_occ_o;
                        n_o_tcnt = r_occ_o;
                    end else begin
                        occ_we   = 1'b1;
                        occ_wa   = node_idx;
                        occ_wd   = r_occ_o - 16'd1;
                        n_o_ocnt = r_occ_o - 16'd1;
                        n_tcnt   = 16'(occ_rd + 16'd1);
                        n_state  = S_WR2;
                    end
                end else begin
                    finish     = 1'b1;
                    n_o_status = ST_FULL;
                    n_o_ocnt   = r_occ_o;
                    n_o_tcnt   = occ_rd;
                end
            end
            S_WR2: begin
                occ_we   = 1'b1;
                occ_wa   = r_target[AW-1:0];
                occ_wd   = r_tcnt;
                n_o_tcnt = r_tcnt;
                finish   = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        if (finish) begin
            n_ov    = 1'b1;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_func     <= n_func;
        r_node     <= n_node;
        r_row      <= n_row;
        r_cap_in   <= n_cap_in;
        r_pick     <= n_pick;
        r_nb       <= n_nb;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_target   <= n_target;
        r_occ_o    <= n_occ_o;
        r_tcnt     <= n_tcnt;
        r_o_status <= n_o_status;
        r_o_target <= n_o_target;
        r_o_ocnt   <= n_o_ocnt;
        r_o_tcnt   <= n_o_tcnt;
    end

    assign o_valid        = r_ov;
    assign o_status       = r_o_status;
    assign o_target_node  = r_o_target;
    assign o_origin_count = r_o_ocnt;
    assign o_target_count = r_o_tcnt;

endmodule
